// File: rtl/bsa_pkg.sv
package bsa_pkg;

  // Fixed-point formats of the ports
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned ANGLE_BITS   = 16;
  localparam int unsigned CORDIC_STEPS = 18;
  localparam int unsigned TURN_W       = 32;

  localparam int unsigned CRD_W  = 32;  // coordinate
  localparam int unsigned BUL_W  = 24;  // bulge
  localparam int unsigned MB_W   = 24;  // bulge magnitude
  localparam int unsigned TOL_W  = 16;  // line tolerance register
  localparam int unsigned C_W    = 33;  // chord component
  localparam int unsigned B2_W   = 47;  // bulge squared
  localparam int unsigned TM_W   = 46;  // |1 - b^2|
  localparam int unsigned RS_W   = 47;  // 1 + b^2
  localparam int unsigned SQ_W   = 66;  // squared chord length
  localparam int unsigned ROOT_W = 33;  // chord length
  localparam int unsigned REM_W  = 35;  // square root remainder
  localparam int unsigned NC_W   = 79;  // center offset numerator
  localparam int unsigned QC_W   = 41;  // center offset quotient
  localparam int unsigned DC_W   = 41;  // center offset divisor
  localparam int unsigned NR_W   = 80;  // radius numerator
  localparam int unsigned QR_W   = 48;  // radius quotient
  localparam int unsigned DR_W   = 42;  // radius divisor
  localparam int unsigned TX_W   = 42;  // doubled center
  localparam int unsigned VEC_W  = 43;  // vector from center, doubled

  localparam logic [QC_W-1:0] OFFSET_MAX = QC_W'(1) << (QC_W - 1);
  localparam logic [QR_W-1:0] RADIUS_MAX = '1;
  localparam logic [B2_W-1:0] ONE_SQ     = B2_W'(1) << (2 * FRAC_BITS);

  // atan(2^-i) in 2^-32 turn units
  localparam logic [TURN_W-1:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Fields waiting for the center offset quotient
  typedef struct packed {
    logic signed [CRD_W-1:0] sx;
    logic signed [CRD_W-1:0] sy;
    logic signed [CRD_W-1:0] ex;
    logic signed [CRD_W-1:0] ey;
    logic                    bneg;
    logic                    tneg;
    logic                    cy_pos;
    logic                    cx_neg;
    logic                    is_arc;
  } ctr_pl_t;

  // Fields waiting for the angles
  typedef struct packed {
    logic signed [CRD_W-1:0] sx;
    logic signed [CRD_W-1:0] sy;
    logic signed [CRD_W-1:0] ex;
    logic signed [CRD_W-1:0] ey;
    logic                    bneg;
    logic                    is_arc;
    logic                    sat;
    logic signed [CRD_W-1:0] ccx;
    logic signed [CRD_W-1:0] ccy;
  } fin_pl_t;

  // Fields waiting for the radius
  typedef struct packed {
    fin_pl_t                 base;
    logic [ANGLE_BITS-1:0]   sa;
    logic [ANGLE_BITS-1:0]   ea;
  } ang_pl_t;

  // Fields waiting for the chord length
  typedef struct packed {
    logic [RS_W-1:0] rsum;
    logic [MB_W-1:0] mb;
  } rad_pl_t;

endpackage

// File: rtl/bsa_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// ovf_o flags a quotient of 2^QUO_W or more.
module bsa_div #(
  parameter int unsigned NUM_W = 79,
  parameter int unsigned DEN_W = 41,
  parameter int unsigned QUO_W = 41
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  localparam int unsigned HI_W  = NUM_W - QUO_W;
  localparam int unsigned CMP_W = HI_W + DEN_W;

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];

  logic [CMP_W-1:0] hi_ext;
  logic [CMP_W-1:0] den_ext;

  assign hi_ext  = CMP_W'(num_i[NUM_W-1:QUO_W]);
  assign den_ext = CMP_W'(den_i);

  // Check for overflow and load the high part as first remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= (hi_ext >= den_ext);
      rem_q[0] <= hi_ext[DEN_W-1:0];
      den_q[0] <= den_i;
      lo_q[0]  <= num_i[QUO_W-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar gk = 1; gk <= QUO_W; gk++) begin : g_step
    logic [DEN_W:0] r2;
    logic           ge;
    assign r2 = {rem_q[gk-1], lo_q[gk-1][QUO_W-1]};
    assign ge = (r2 >= {1'b0, den_q[gk-1]});

    // Subtract when the divisor fits, shift in one quotient bit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[gk] <= {quo_q[gk-1][QUO_W-2:0], ge};
        ovf_q[gk] <= ovf_q[gk-1];
      end
    end

    if (gk < QUO_W) begin : g_carry
      logic [DEN_W:0] diff;
      assign diff = r2 - {1'b0, den_q[gk-1]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[gk] <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
          den_q[gk] <= den_q[gk-1];
          lo_q[gk]  <= lo_q[gk-1] << 1;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

// File: rtl/bsa_cordic.sv
// Pipelined vectoring CORDIC: angle of (x, y) in binary angle units.
// A zero vector gives angle zero.
module bsa_cordic import bsa_pkg::*; #(
  parameter int unsigned IN_W = 43
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [IN_W-1:0] x_i,
  input  logic signed [IN_W-1:0] y_i,
  output logic [ANGLE_BITS-1:0]  angle_o
);

  localparam int unsigned CW = IN_W + 3;
  localparam int unsigned N  = CORDIC_STEPS;
  localparam logic [TURN_W-1:0] HALF_TURN = TURN_W'(1) << (TURN_W - 1);
  localparam logic [TURN_W-1:0] ROUND_BIT = TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS);

  logic signed [CW-1:0]     x_q  [N];
  logic signed [CW-1:0]     y_q  [N];
  logic        [TURN_W-1:0] z_q  [N+1];
  logic                     zf_q [N+1];
  logic [ANGLE_BITS-1:0]    ang_q;

  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  logic        [TURN_W-1:0] zr;

  assign xe = CW'(x_i);
  assign ye = CW'(y_i);

  // Fold the left half plane onto the right one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zf_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -xe;
        y_q[0] <= -ye;
        z_q[0] <= HALF_TURN;
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar gk = 0; gk < N; gk++) begin : g_iter
    logic up;
    assign up = (y_q[gk] > 0);

    // Rotate toward the x axis and accumulate the angle
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[gk+1]  <= up ? z_q[gk] + ATAN_TURNS[gk] : z_q[gk] - ATAN_TURNS[gk];
        zf_q[gk+1] <= zf_q[gk];
      end
    end

    if (gk < N - 1) begin : g_rot
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      assign xs = x_q[gk] >>> gk;
      assign ys = y_q[gk] >>> gk;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[gk+1] <= up ? x_q[gk] + ys : x_q[gk] - ys;
          y_q[gk+1] <= up ? y_q[gk] - xs : y_q[gk] + xs;
        end
      end
    end
  end

  // Round to the output resolution
  assign zr = z_q[N] + ROUND_BIT;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= zf_q[N] ? '0 : zr[TURN_W-1 -: ANGLE_BITS];
    end
  end

  assign angle_o = ang_q;

endmodule

// File: rtl/bulge_segment_to_arc.sv
// Polyline bulge segment to arc converter.
// Input transaction (s_axis): anchor point, new vertex and bulge in tdata,
// prepend flag in tuser. Output transaction (m_axis): segment end points,
// center, radius, start and end angle, direction and saturation flag in
// tdata, the arc/line kind in tuser.
// The cfg channel writes the line tolerance; it is always ready and is
// meant to be written while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled. The
// longest path from input acceptance to output valid runs through the chord
// length square root (33 stages) followed by the 48-bit radius divider (49 stages).
// The pipeline advances as one: when the output holds a result that the
// receiver does not take, every stage holds and s_axis_tready drops;
// nothing is lost or repeated.
// Reset clears all valid bits and sets the line tolerance to 1.
module bulge_segment_to_arc import bsa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // anchor_x, anchor_y, vertex_x, vertex_y, bulge
  input  logic [151:0] s_axis_tdata,
  // prepend
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, center_x, center_y,
  // radius, start_angle, end_angle, clockwise, out_of_range, zero pad
  output logic [279:0] m_axis_tdata,
  // is_arc
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  localparam int unsigned ST_D     = 4;
  localparam int unsigned CDIV_LAT = QC_W + 1;
  localparam int unsigned RDIV_LAT = QR_W + 1;
  localparam int unsigned CRD_LAT  = CORDIC_STEPS + 2;
  localparam int unsigned ST_E     = ST_D + 1;
  localparam int unsigned ST_G     = ST_E + CDIV_LAT + 2;
  localparam int unsigned ST_ANG   = ST_G + CRD_LAT;
  localparam int unsigned ST_I     = ST_D + ROOT_W + 2;
  localparam int unsigned ST_RAD   = ST_I + RDIV_LAT;
  localparam int unsigned FIN_DLY  = ST_RAD - ST_ANG;
  localparam int unsigned PIPE_LAT = ST_RAD + 1;

  logic adv;
  logic [PIPE_LAT-1:0] vld_q;
  logic [TOL_W-1:0] tol_q;

  // Advance everything unless a finished result is blocked
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[PIPE_LAT-1];
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(1);
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // Stage A: order the end points, take the bulge magnitude
  logic signed [CRD_W-1:0] in_ax, in_ay, in_vx, in_vy;
  logic signed [BUL_W-1:0] in_b;
  logic        [MB_W-1:0]  in_mb;

  assign in_ax = s_axis_tdata[31:0];
  assign in_ay = s_axis_tdata[63:32];
  assign in_vx = s_axis_tdata[95:64];
  assign in_vy = s_axis_tdata[127:96];
  assign in_b  = s_axis_tdata[151:128];
  assign in_mb = in_b[BUL_W-1] ? MB_W'(-in_b) : MB_W'(in_b);

  logic signed [CRD_W-1:0] a_sx_q, a_sy_q, a_ex_q, a_ey_q;
  logic        [MB_W-1:0]  a_mb_q;
  logic                    a_bneg_q, a_arc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_sx_q   <= s_axis_tuser ? in_vx : in_ax;
      a_sy_q   <= s_axis_tuser ? in_vy : in_ay;
      a_ex_q   <= s_axis_tuser ? in_ax : in_vx;
      a_ey_q   <= s_axis_tuser ? in_ay : in_vy;
      a_mb_q   <= in_mb;
      a_bneg_q <= in_b[BUL_W-1];
      a_arc_q  <= (in_mb != '0) && (in_mb >= MB_W'(tol_q));
    end
  end

  // Stage B: chord vector and bulge squared
  logic signed [C_W-1:0]  b_cx_q, b_cy_q;
  logic        [B2_W-1:0] b_b2_q;
  logic signed [CRD_W-1:0] b_sx_q, b_sy_q, b_ex_q, b_ey_q;
  logic        [MB_W-1:0]  b_mb_q;
  logic                    b_bneg_q, b_arc_q;
  logic        [B2_W-1:0]  a_mbx;

  assign a_mbx = B2_W'(a_mb_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_cx_q   <= C_W'(a_ex_q) - C_W'(a_sx_q);
      b_cy_q   <= C_W'(a_ey_q) - C_W'(a_sy_q);
      b_b2_q   <= a_mbx * a_mbx;
      b_sx_q   <= a_sx_q;
      b_sy_q   <= a_sy_q;
      b_ex_q   <= a_ex_q;
      b_ey_q   <= a_ey_q;
      b_mb_q   <= a_mb_q;
      b_bneg_q <= a_bneg_q;
      b_arc_q  <= a_arc_q;
    end
  end

  // Stage C: squares of the chord, 1 - b^2 and 1 + b^2
  logic [C_W-1:0]  b_cxm, b_cym;
  logic [SQ_W-1:0] b_cxsq, b_cysq;
  logic            b_tneg;

  assign b_cxm  = b_cx_q[C_W-1] ? C_W'(-b_cx_q) : C_W'(b_cx_q);
  assign b_cym  = b_cy_q[C_W-1] ? C_W'(-b_cy_q) : C_W'(b_cy_q);
  assign b_cxsq = SQ_W'(b_cxm) * SQ_W'(b_cxm);
  assign b_cysq = SQ_W'(b_cym) * SQ_W'(b_cym);
  assign b_tneg = (b_b2_q > ONE_SQ);

  logic [SQ_W-1:0] c_cxsq_q, c_cysq_q;
  logic [TM_W-1:0] c_tm_q;
  logic [RS_W-1:0] c_rsum_q;
  logic [C_W-1:0]  c_cxm_q, c_cym_q;
  logic            c_tneg_q, c_cypos_q, c_cxneg_q;
  logic signed [CRD_W-1:0] c_sx_q, c_sy_q, c_ex_q, c_ey_q;
  logic        [MB_W-1:0]  c_mb_q;
  logic                    c_bneg_q, c_arc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_cxsq_q  <= b_cxsq;
      c_cysq_q  <= b_cysq;
      c_tm_q    <= b_tneg ? TM_W'(b_b2_q - ONE_SQ) : TM_W'(ONE_SQ - b_b2_q);
      c_rsum_q  <= RS_W'(ONE_SQ + b_b2_q);
      c_cxm_q   <= b_cxm;
      c_cym_q   <= b_cym;
      c_tneg_q  <= b_tneg;
      c_cypos_q <= !b_cy_q[C_W-1] && (b_cy_q != '0);
      c_cxneg_q <= b_cx_q[C_W-1];
      c_sx_q    <= b_sx_q;
      c_sy_q    <= b_sy_q;
      c_ex_q    <= b_ex_q;
      c_ey_q    <= b_ey_q;
      c_mb_q    <= b_mb_q;
      c_bneg_q  <= b_bneg_q;
      c_arc_q   <= b_arc_q;
    end
  end

  // Stage D: squared chord length, partial products of |c| * |1 - b^2|
  localparam int unsigned TH_W = TM_W / 2;
  localparam int unsigned PP_W = C_W + TH_W;

  logic [PP_W-1:0] c_cym_e, c_cxm_e, c_tlo_e, c_thi_e;

  assign c_cym_e = PP_W'(c_cym_q);
  assign c_cxm_e = PP_W'(c_cxm_q);
  assign c_tlo_e = PP_W'(c_tm_q[TH_W-1:0]);
  assign c_thi_e = PP_W'(c_tm_q[TM_W-1:TH_W]);

  logic [SQ_W-1:0] d_v_q;
  logic [PP_W-1:0] d_pxlo_q, d_pxhi_q, d_pylo_q, d_pyhi_q;
  logic [RS_W-1:0] d_rsum_q;
  logic            d_tneg_q, d_cypos_q, d_cxneg_q;
  logic signed [CRD_W-1:0] d_sx_q, d_sy_q, d_ex_q, d_ey_q;
  logic        [MB_W-1:0]  d_mb_q;
  logic                    d_bneg_q, d_arc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_v_q     <= c_cxsq_q + c_cysq_q;
      d_pxlo_q  <= c_cym_e * c_tlo_e;
      d_pxhi_q  <= c_cym_e * c_thi_e;
      d_pylo_q  <= c_cxm_e * c_tlo_e;
      d_pyhi_q  <= c_cxm_e * c_thi_e;
      d_rsum_q  <= c_rsum_q;
      d_tneg_q  <= c_tneg_q;
      d_cypos_q <= c_cypos_q;
      d_cxneg_q <= c_cxneg_q;
      d_sx_q    <= c_sx_q;
      d_sy_q    <= c_sy_q;
      d_ex_q    <= c_ex_q;
      d_ey_q    <= c_ey_q;
      d_mb_q    <= c_mb_q;
      d_bneg_q  <= c_bneg_q;
      d_arc_q   <= c_arc_q;
    end
  end

  // Stage E: offset numerators and divisor
  logic [NC_W-1:0] e_nx_q, e_ny_q;
  logic [DC_W-1:0] e_den_q;
  ctr_pl_t         e_pl_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_nx_q         <= NC_W'(d_pxlo_q) + NC_W'({d_pxhi_q, TH_W'(0)});
      e_ny_q         <= NC_W'(d_pylo_q) + NC_W'({d_pyhi_q, TH_W'(0)});
      e_den_q        <= DC_W'({d_mb_q, (FRAC_BITS + 1)'(0)});
      e_pl_q.sx      <= d_sx_q;
      e_pl_q.sy      <= d_sy_q;
      e_pl_q.ex      <= d_ex_q;
      e_pl_q.ey      <= d_ey_q;
      e_pl_q.bneg    <= d_bneg_q;
      e_pl_q.tneg    <= d_tneg_q;
      e_pl_q.cy_pos  <= d_cypos_q;
      e_pl_q.cx_neg  <= d_cxneg_q;
      e_pl_q.is_arc  <= d_arc_q;
    end
  end

  // Center offset dividers
  logic [QC_W-1:0] qx_quo, qy_quo;
  logic            qx_ovf, qy_ovf;

  bsa_div #(.NUM_W(NC_W), .DEN_W(DC_W), .QUO_W(QC_W)) u_div_cx (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (e_nx_q),
    .den_i (e_den_q),
    .quo_o (qx_quo),
    .ovf_o (qx_ovf)
  );

  bsa_div #(.NUM_W(NC_W), .DEN_W(DC_W), .QUO_W(QC_W)) u_div_cy (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (e_ny_q),
    .den_i (e_den_q),
    .quo_o (qy_quo),
    .ovf_o (qy_ovf)
  );

  // Hold the side fields for the length of the divider
  ctr_pl_t cpl_q [CDIV_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cpl_q[0] <= e_pl_q;
      for (int i = 1; i < CDIV_LAT; i++) begin
        cpl_q[i] <= cpl_q[i-1];
      end
    end
  end

  // Stage F: clamp the offsets and form the doubled center
  ctr_pl_t               cpl;
  logic [QC_W-1:0]       qx, qy;
  logic                  negx, negy;
  logic signed [TX_W-1:0] sumx, sumy, qxs, qys;

  assign cpl  = cpl_q[CDIV_LAT-1];
  assign qx   = (qx_ovf || (qx_quo > OFFSET_MAX)) ? OFFSET_MAX : qx_quo;
  assign qy   = (qy_ovf || (qy_quo > OFFSET_MAX)) ? OFFSET_MAX : qy_quo;
  assign negx = cpl.cy_pos ^ cpl.tneg ^ cpl.bneg;
  assign negy = cpl.cx_neg ^ cpl.tneg ^ cpl.bneg;
  assign sumx = TX_W'(cpl.sx) + TX_W'(cpl.ex);
  assign sumy = TX_W'(cpl.sy) + TX_W'(cpl.ey);
  assign qxs  = $signed(TX_W'(qx));
  assign qys  = $signed(TX_W'(qy));

  logic signed [TX_W-1:0] f_tx_q, f_ty_q;
  logic signed [CRD_W-1:0] f_sx_q, f_sy_q, f_ex_q, f_ey_q;
  logic                    f_bneg_q, f_arc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_tx_q   <= negx ? sumx - qxs : sumx + qxs;
      f_ty_q   <= negy ? sumy - qys : sumy + qys;
      f_sx_q   <= cpl.sx;
      f_sy_q   <= cpl.sy;
      f_ex_q   <= cpl.ex;
      f_ey_q   <= cpl.ey;
      f_bneg_q <= cpl.bneg;
      f_arc_q  <= cpl.is_arc;
    end
  end

  // Stage G: saturate the center, vectors from center to the end points
  localparam logic signed [TX_W-2:0] CRD_MAX = (TX_W-1)'(2147483647);
  localparam logic signed [TX_W-2:0] CRD_MIN = -CRD_MAX - 1;

  logic signed [TX_W-2:0] hx, hy;
  logic                   hx_hi, hx_lo, hy_hi, hy_lo;

  assign hx    = (TX_W-1)'(f_tx_q >>> 1);
  assign hy    = (TX_W-1)'(f_ty_q >>> 1);
  assign hx_hi = (hx > CRD_MAX);
  assign hx_lo = (hx < CRD_MIN);
  assign hy_hi = (hy > CRD_MAX);
  assign hy_lo = (hy < CRD_MIN);

  fin_pl_t                 g_pl_q;
  logic signed [VEC_W-1:0] g_vsx_q, g_vsy_q, g_vex_q, g_vey_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_pl_q.sx     <= f_sx_q;
      g_pl_q.sy     <= f_sy_q;
      g_pl_q.ex     <= f_ex_q;
      g_pl_q.ey     <= f_ey_q;
      g_pl_q.bneg   <= f_bneg_q;
      g_pl_q.is_arc <= f_arc_q;
      g_pl_q.sat    <= hx_hi || hx_lo || hy_hi || hy_lo;
      g_pl_q.ccx    <= hx_hi ? CRD_W'(CRD_MAX) : (hx_lo ? CRD_W'(CRD_MIN) : CRD_W'(hx));
      g_pl_q.ccy    <= hy_hi ? CRD_W'(CRD_MAX) : (hy_lo ? CRD_W'(CRD_MIN) : CRD_W'(hy));
      g_vsx_q       <= (VEC_W'(f_sx_q) <<< 1) - VEC_W'(f_tx_q);
      g_vsy_q       <= (VEC_W'(f_sy_q) <<< 1) - VEC_W'(f_ty_q);
      g_vex_q       <= (VEC_W'(f_ex_q) <<< 1) - VEC_W'(f_tx_q);
      g_vey_q       <= (VEC_W'(f_ey_q) <<< 1) - VEC_W'(f_ty_q);
    end
  end

  // Start and end angles
  logic [ANGLE_BITS-1:0] ang_s, ang_e;

  bsa_cordic #(.IN_W(VEC_W)) u_cordic_s (
    .clk_i   (clk_i),
    .en_i    (adv),
    .x_i     (g_vsx_q),
    .y_i     (g_vsy_q),
    .angle_o (ang_s)
  );

  bsa_cordic #(.IN_W(VEC_W)) u_cordic_e (
    .clk_i   (clk_i),
    .en_i    (adv),
    .x_i     (g_vex_q),
    .y_i     (g_vey_q),
    .angle_o (ang_e)
  );

  fin_pl_t fpl_q [CRD_LAT];
  ang_pl_t apl_q [FIN_DLY];
  ang_pl_t apl_in;

  assign apl_in.base = fpl_q[CRD_LAT-1];
  assign apl_in.sa   = ang_s;
  assign apl_in.ea   = ang_e;

  // Carry center results alongside the angle units, then wait for the radius
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fpl_q[0] <= g_pl_q;
      for (int i = 1; i < CRD_LAT; i++) begin
        fpl_q[i] <= fpl_q[i-1];
      end
      apl_q[0] <= apl_in;
      for (int i = 1; i < FIN_DLY; i++) begin
        apl_q[i] <= apl_q[i-1];
      end
    end
  end

  // Chord length: one root bit per stage
  logic [REM_W-1:0]  sq_rem_q  [ROOT_W];
  logic [ROOT_W-1:0] sq_root_q [ROOT_W];
  logic [SQ_W-1:0]   sq_v_q    [ROOT_W];

  for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_sqrt
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   v_in;
    logic [REM_W+1:0]  r4, trial, diff;

    if (gi == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = d_v_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[gi-1];
      assign root_in = sq_root_q[gi-1];
      assign v_in    = sq_v_q[gi-1];
    end

    assign r4    = {rem_in, v_in[SQ_W-1 -: 2]};
    assign trial = (REM_W + 2)'({root_in, 2'b01});
    assign diff  = r4 - trial;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_v_q[gi] <= v_in << 2;
        if (r4 >= trial) begin
          sq_rem_q[gi]  <= diff[REM_W-1:0];
          sq_root_q[gi] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_q[gi]  <= r4[REM_W-1:0];
          sq_root_q[gi] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  rad_pl_t rpl_q [ROOT_W];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rpl_q[0] <= '{rsum: d_rsum_q, mb: d_mb_q};
      for (int i = 1; i < ROOT_W; i++) begin
        rpl_q[i] <= rpl_q[i-1];
      end
    end
  end

  // Stage H: partial products of |c| * (1 + b^2)
  localparam int unsigned RL_W = 24;
  localparam int unsigned RP_W = ROOT_W + RL_W;

  rad_pl_t          rpl;
  logic [RP_W-1:0]  len_e, rlo_e, rhi_e;

  assign rpl   = rpl_q[ROOT_W-1];
  assign len_e = RP_W'(sq_root_q[ROOT_W-1]);
  assign rlo_e = RP_W'(rpl.rsum[RL_W-1:0]);
  assign rhi_e = RP_W'(rpl.rsum[RS_W-1:RL_W]);

  logic [RP_W-1:0] h_plo_q, h_phi_q;
  logic [MB_W-1:0] h_mb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_plo_q <= len_e * rlo_e;
      h_phi_q <= len_e * rhi_e;
      h_mb_q  <= rpl.mb;
    end
  end

  // Stage I: radius numerator and divisor
  logic [NR_W-1:0] i_nr_q;
  logic [DR_W-1:0] i_den_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      i_nr_q  <= NR_W'(h_plo_q) + NR_W'({h_phi_q, RL_W'(0)});
      i_den_q <= DR_W'({h_mb_q, (FRAC_BITS + 2)'(0)});
    end
  end

  logic [QR_W-1:0] r_quo;
  logic            r_ovf;

  bsa_div #(.NUM_W(NR_W), .DEN_W(DR_W), .QUO_W(QR_W)) u_div_rad (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (i_nr_q),
    .den_i (i_den_q),
    .quo_o (r_quo),
    .ovf_o (r_ovf)
  );

  // Output register: zero the arc fields of a straight line
  ang_pl_t         fin;
  logic            arc;
  logic [279:0]    tdata_d;
  logic [279:0]    tdata_q;
  logic            tuser_q;
  logic [QR_W-1:0] rad;

  assign fin = apl_q[FIN_DLY-1];
  assign arc = fin.base.is_arc;
  assign rad = r_ovf ? RADIUS_MAX : r_quo;

  always_comb begin
    tdata_d            = '0;
    tdata_d[31:0]      = fin.base.sx;
    tdata_d[63:32]     = fin.base.sy;
    tdata_d[95:64]     = fin.base.ex;
    tdata_d[127:96]    = fin.base.ey;
    if (arc) begin
      tdata_d[159:128] = fin.base.ccx;
      tdata_d[191:160] = fin.base.ccy;
      tdata_d[239:192] = rad;
      tdata_d[255:240] = fin.sa;
      tdata_d[271:256] = fin.ea;
      tdata_d[272]     = fin.base.bneg;
      tdata_d[273]     = fin.base.sat || r_ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdata_q <= tdata_d;
      tuser_q <= arc;
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;

`ifndef SYNTHESIS
  a_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[279:128] == '0)
    else $error("line result carries arc fields");

  a_flags_arc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[272] || m_axis_tdata[273]) |-> m_axis_tuser)
    else $error("direction or saturation flag on a line");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[0]) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("pipeline valid set without an input transaction");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule

// File: test/testbench.sv
module testbench;
  import bsa_pkg::*;

  localparam int unsigned LATENCY     = 89;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] ax, ay, vx, vy;
    logic        [23:0] bulge;
    logic               pre;
  } segment_t;

  typedef struct {
    logic               is_arc;
    logic        [31:0] sx, sy, ex, ey, cx, cy;
    logic        [47:0] radius;
    logic        [15:0] sa, ea;
    logic               cw, oor;
  } arc_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [279:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  segment_t    pending_segs[$];
  arc_t        expected_arcs[$];
  logic [15:0] tol_shadow = 16'd1;
  int          errors = 0;
  int          cycles = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;

  bulge_segment_to_arc dut (.*);

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Floor square root of a wide value
  function automatic logic [127:0] chord_root(logic [127:0] v);
    logic [127:0] res, cand;
    res = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  // Vectoring CORDIC angle in binary angle units
  function automatic logic [15:0] vector_angle(longint x, longint y);
    logic [31:0] z;
    longint xs, ys;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_TURNS[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TURNS[i];
      end
    end
    z += 32'd1 << (31 - ANGLE_BITS);
    return z[31:16];
  endfunction

  // Work out the line or arc for one segment
  function automatic arc_t segment_geometry(segment_t s);
    arc_t r;
    longint b, sx, sy, ex, ey, cx, cy, t, tx, ty, ccx, ccy;
    logic [127:0] mb, b2, q_x, q_y, len, rad, mcx, mcy, mt;
    bit negx, negy;
    b  = longint'($signed(s.bulge));
    sx = s.pre ? s.vx : s.ax;  sy = s.pre ? s.vy : s.ay;
    ex = s.pre ? s.ax : s.vx;  ey = s.pre ? s.ay : s.vy;
    r = '{default: '0};
    r.sx = 32'(sx); r.sy = 32'(sy); r.ex = 32'(ex); r.ey = 32'(ey);
    mb = (b < 0) ? -b : b;
    if (b == 0 || mb < tol_shadow) return r;
    cx = ex - sx;  cy = ey - sy;
    mcx = (cx < 0) ? -cx : cx;
    mcy = (cy < 0) ? -cy : cy;
    b2 = mb * mb;
    t = (longint'(1) << 32) - longint'(b2);
    mt = (t < 0) ? -t : t;
    q_x = (mcy * mt) / (mb << (FRAC_BITS + 1));
    q_y = (mcx * mt) / (mb << (FRAC_BITS + 1));
    if (q_x > (128'd1 << 40)) q_x = 128'd1 << 40;
    if (q_y > (128'd1 << 40)) q_y = 128'd1 << 40;
    negx = (cy > 0) ^ (t < 0) ^ (b < 0);
    negy = (cx < 0) ^ (t < 0) ^ (b < 0);
    tx = sx + ex + (negx ? -longint'(q_x) : longint'(q_x));
    ty = sy + ey + (negy ? -longint'(q_y) : longint'(q_y));
    ccx = tx >>> 1;
    ccy = ty >>> 1;
    if (ccx > 64'sh7FFF_FFFF)  begin ccx = 64'sh7FFF_FFFF;  r.oor = 1'b1; end
    if (ccx < -64'sh8000_0000) begin ccx = -64'sh8000_0000; r.oor = 1'b1; end
    if (ccy > 64'sh7FFF_FFFF)  begin ccy = 64'sh7FFF_FFFF;  r.oor = 1'b1; end
    if (ccy < -64'sh8000_0000) begin ccy = -64'sh8000_0000; r.oor = 1'b1; end
    len = chord_root(mcx * mcx + mcy * mcy);
    rad = (len * ((128'd1 << 32) + b2)) / (mb << (FRAC_BITS + 2));
    if (rad > {48{1'b1}}) begin
      rad = {48{1'b1}};
      r.oor = 1'b1;
    end
    r.is_arc = 1'b1;
    r.cx = 32'(ccx);  r.cy = 32'(ccy);
    r.radius = rad[47:0];
    r.sa = vector_angle(2 * sx - tx, 2 * sy - ty);
    r.ea = vector_angle(2 * ex - tx, 2 * ey - ty);
    r.cw = (b < 0);
    return r;
  endfunction

  // Input side: hold each transaction until taken, then idle a drawn while
  int  send_wait = 0;
  int  sent_cnt  = 0;
  int  taken_cnt = 0;
  always @(negedge clk_i) begin
    segment_t s;
    logic next_valid;
    next_valid = s_axis_tvalid;
    if (rst_ni && (sent_cnt == taken_cnt)) begin
      next_valid = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
      end else if (pending_segs.size() > 0) begin
        s = pending_segs.pop_front();
        sent_cnt++;
        s_axis_tdata <= {s.bulge, s.vy, s.vx, s.ay, s.ax};
        s_axis_tuser <= s.pre;
        next_valid = 1'b1;
        send_wait = send_gaps ? $urandom_range(0, 13) : 0;
      end
    end
    s_axis_tvalid <= next_valid;
  end

  // Predict on every accepted input transaction
  always @(posedge clk_i) begin
    segment_t s;
    if (s_axis_tvalid && s_axis_tready) begin
      {s.bulge, s.vy, s.vx, s.ay, s.ax} = s_axis_tdata;
      s.pre = s_axis_tuser;
      expected_arcs = {expected_arcs, segment_geometry(s)};
      taken_cnt++;
    end
  end

  // Output side stall
  int recv_wait = 0;
  int out_cnt   = 0;
  int seen_cnt  = 0;
  always @(negedge clk_i) begin
    if (out_cnt != seen_cnt) begin
      seen_cnt  = out_cnt;
      recv_wait = recv_gaps ? $urandom_range(0, 13) : 0;
    end
    if (!rst_ni || recv_wait > 0) begin
      if (rst_ni) recv_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    arc_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (m_axis_tvalid && m_axis_tready) begin
      out_cnt++;
      if (expected_arcs.size() == 0) begin
        $error("output transaction with no prediction pending");
        errors++;
      end else begin
        e = expected_arcs.pop_front();
        check_field("is_arc", e.is_arc, m_axis_tuser);
        check_field("seg_start_x", e.sx, m_axis_tdata[31:0]);
        check_field("seg_start_y", e.sy, m_axis_tdata[63:32]);
        check_field("seg_end_x", e.ex, m_axis_tdata[95:64]);
        check_field("seg_end_y", e.ey, m_axis_tdata[127:96]);
        check_field("center_x", e.cx, m_axis_tdata[159:128]);
        check_field("center_y", e.cy, m_axis_tdata[191:160]);
        check_field("radius", e.radius, m_axis_tdata[239:192]);
        check_field("start_angle", e.sa, m_axis_tdata[255:240]);
        check_field("end_angle", e.ea, m_axis_tdata[271:256]);
        check_field("clockwise", e.cw, m_axis_tdata[272]);
        check_field("out_of_range", e.oor, m_axis_tdata[273]);
      end
    end
  end

  task automatic write_tolerance(logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    tol_shadow = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain;
    wait (pending_segs.size() == 0 && sent_cnt == taken_cnt && expected_arcs.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic add_seg(logic [31:0] ax, ay, vx, vy, logic [23:0] b, logic pre);
    segment_t s;
    s.ax = ax; s.ay = ay; s.vx = vx; s.vy = vy; s.bulge = b; s.pre = pre;
    pending_segs = {pending_segs, s};
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
  endfunction

  function automatic logic [23:0] rand_bulge();
    logic [23:0] m;
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 24'h4_0000)) - 24'h2_0000;
      2: begin
        m = 24'(tol_shadow) + 24'($urandom_range(0, 6)) - 24'd3;
        return $urandom_range(0, 1) ? m : -m;
      end
      3: return $urandom_range(0, 1) ? 24'h01_0000 : 24'hFF_0000;
      4: return 24'd0;
      default: return 24'($urandom_range(0, 24'h2_0000)) - 24'h1_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] ax, ay;
    logic [15:0] tols[5];
    tols = '{16'd1, 16'd65535, 16'd1000, 16'd1, 16'd0};
    tols[4] = 16'($urandom_range(1, 65535));
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, straight lines, half circles, coincident points
    add_seg(32'h0, 32'h0, 32'h0001_0000, 32'h0, 24'h0, 1'b0);
    add_seg(32'h0, 32'h0, 32'h0001_0000, 32'h0, 24'h1, 1'b0);
    add_seg(32'h0, 32'h0, 32'h0001_0000, 32'h0, 24'hFF_FFFF, 1'b1);
    add_seg(32'h0, 32'h0, 32'h0002_0000, 32'h0, 24'h01_0000, 1'b0);
    add_seg(32'h0, 32'h0, 32'h0002_0000, 32'h0, 24'hFF_0000, 1'b1);
    add_seg(32'h0, 32'h0, 32'h0, 32'h0002_0000, 24'h00_6A0A, 1'b0);
    add_seg(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
            24'h00_8000, 1'b0);
    add_seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            24'h7F_FFFF, 1'b0);
    add_seg(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            24'h80_0000, 1'b1);
    add_seg(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            24'h00_0001, 1'b0);
    add_seg(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            24'hFF_FFFF, 1'b0);
    add_seg(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 24'h02_0000, 1'b1);
    add_seg(32'h1234_5678, 32'hEDCB_A988, 32'h1234_0000, 32'hEDCC_0000,
            24'h00_4000, 1'b0);
    add_seg(32'h0, 32'h0, 32'hFFF0_0000, 32'h0010_0000, 24'hFF_C000, 1'b1);

    foreach (tols[p]) begin
      if (p > 0) write_tolerance(tols[p]);
      send_gaps = (p != 2);
      recv_gaps = (p != 1);
      if (p == 1) begin
        add_seg(32'h0, 32'h0, 32'h0001_0000, 32'h0, 24'h00_FFFE, 1'b0);
        add_seg(32'h0, 32'h0, 32'h0001_0000, 32'h0, 24'hFF_0001, 1'b0);
        add_seg(32'h0, 32'h0, 32'h0001_0000, 32'h0, 24'h00_FFFF, 1'b1);
      end
      repeat (118) begin
        ax = rand_coord();
        ay = rand_coord();
        case ($urandom_range(0, 9))
          0: add_seg(ax, ay, ax, ay, rand_bulge(), 1'($urandom_range(0, 1)));
          1: add_seg(ax, ay, $urandom, $urandom, rand_bulge(),
                     1'($urandom_range(0, 1)));
          default: add_seg(ax, ay, ax + rand_coord(), ay + rand_coord(),
                           rand_bulge(), 1'($urandom_range(0, 1)));
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
